// ----- sv/sct_pkg.sv -----
// Shared types, constants and helper functions of the SMBus command table sequencer.
package sct_pkg;

    localparam int IDX_W             = 4;
    localparam int TABLE_DEPTH       = 1 << IDX_W;
    localparam int MAX_PAYLOAD_BYTES = 4;
    localparam int PAY_W             = 32;
    localparam int PAY_BYTES         = PAY_W / 8;
    localparam int BYTE_SEL_W        = $clog2(PAY_BYTES);

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_EVENT = 2'd2;

    localparam logic [1:0] XFER_NONE     = 2'd0;
    localparam logic [1:0] XFER_WRITE    = 2'd1;
    localparam logic [1:0] XFER_READ_CMD = 2'd2;
    localparam logic [1:0] XFER_RESTART  = 2'd3;

    typedef enum logic [4:0] {
        PH_START = 5'b00001,
        PH_CMD   = 5'b00010,
        PH_WRITE = 5'b00100,
        PH_READ  = 5'b01000,
        PH_STOP  = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        RD_ITEM = 2'd0,
        RD_CUR  = 2'd1,
        RD_NEXT = 2'd2
    } rd_sel_t;

    typedef struct packed {
        logic [7:0]       cmd;
        logic [2:0]       length;
        logic             is_read;
        logic [PAY_W-1:0] payload;
    } entry_t;

    typedef struct packed {
        logic    capture;
        logic    clear;
        logic    write_entry;
        logic    start_seq;
        logic    do_event;
        logic    do_next;
        logic    do_launch;
        rd_sel_t rd_sel;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       active;
        logic       stop_hit;
    } status_t;

    function automatic logic [2:0] clamp_length(input logic [2:0] len);
        logic [2:0] r;
        r = len;
        if (r == 3'd0)
        begin
            r = 3'd1;
        end
        if (r > 3'(MAX_PAYLOAD_BYTES))
        begin
            r = 3'(MAX_PAYLOAD_BYTES);
        end
        return r;
    endfunction

    function automatic logic [7:0] get_byte(input logic [PAY_W-1:0] pay, input logic [2:0] off);
        logic [7:0] r;
        r = 8'd0;
        if (off < 3'(PAY_BYTES))
        begin
            r = pay[{off[BYTE_SEL_W-1:0], 3'b000} +: 8];
        end
        return r;
    endfunction

endpackage

// ----- sv/sct_datapath.sv -----
// Datapath of the sequencer: command table memory, walk registers, event logic and result registers.
module sct_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sct_pkg::cmd_t          cmd,
    output sct_pkg::status_t       status,
    input  logic [1:0]             kind,
    input  logic [3:0]             entry_index,
    input  logic [7:0]             entry_cmd,
    input  logic [2:0]             entry_length,
    input  logic                   entry_is_read,
    input  logic [31:0]            entry_payload,
    input  logic                   request_tick,
    input  logic                   flag_txis,
    input  logic                   flag_rxne,
    input  logic                   flag_stopf,
    input  logic                   flag_tc,
    input  logic [7:0]             rx_byte,
    output logic                   tx_valid,
    output logic [7:0]             tx_byte,
    output logic [1:0]             xfer_kind,
    output logic [2:0]             xfer_count,
    output logic                   accepted,
    output logic                   busy_res,
    output logic                   entry_done,
    output logic [3:0]             done_index,
    output logic [31:0]            done_payload,
    output logic                   sequence_end,
    output logic                   tick_request
);
    import sct_pkg::*;

    entry_t           mem [TABLE_DEPTH];
    entry_t           rd_q;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;

    logic [1:0]       in_kind_reg;
    logic [IDX_W-1:0] in_index_reg;
    logic [7:0]       in_cmd_reg;
    logic [2:0]       in_length_reg;
    logic             in_is_read_reg;
    logic [PAY_W-1:0] in_payload_reg;
    logic             in_tick_reg;
    logic             in_txis_reg;
    logic             in_rxne_reg;
    logic             in_stopf_reg;
    logic             in_tc_reg;
    logic [7:0]       in_rx_reg;

    phase_t           phase_reg;
    logic [2:0]       cnt_reg;
    logic [IDX_W-1:0] cur_reg;
    logic [IDX_W-1:0] next_idx;
    logic             active_reg;
    logic             tick_pending_reg;

    logic             res_tx_valid_reg;
    logic [7:0]       res_tx_byte_reg;
    logic [1:0]       res_xk_reg;
    logic [2:0]       res_xc_reg;
    logic             res_accepted_reg;
    logic             res_entry_done_reg;
    logic [IDX_W-1:0] res_done_index_reg;
    logic [PAY_W-1:0] res_done_payload_reg;
    logic             res_seq_end_reg;
    logic             res_tick_reg;

    phase_t           ev_phase;
    logic [2:0]       ev_cnt;
    logic             ev_tx_valid;
    logic [7:0]       ev_tx_byte;
    logic             ev_wr;
    logic [PAY_W-1:0] ev_pay;
    logic [1:0]       ev_xk;
    logic [2:0]       ev_xc;
    logic             ev_stop;

    logic [1:0]       lau_xk;
    logic [2:0]       lau_xc;

    assign next_idx = cur_reg + IDX_W'(1);

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_ITEM: rd_addr = in_index_reg;
            RD_CUR:  rd_addr = cur_reg;
            RD_NEXT: rd_addr = next_idx;
            default: rd_addr = cur_reg;
        endcase
    end

    always_comb
    begin : event_logic
        phase_t     ph;
        logic [2:0] cnt;
        ph          = phase_reg;
        cnt         = cnt_reg;
        ev_tx_valid = 1'b0;
        ev_tx_byte  = 8'd0;
        ev_wr       = 1'b0;
        ev_pay      = rd_q.payload;
        ev_xk       = XFER_NONE;
        ev_xc       = 3'd0;
        ev_stop     = 1'b0;
        if (in_txis_reg)
        begin
            if (ph == PH_START)
            begin
                ev_tx_valid = 1'b1;
                ev_tx_byte  = rd_q.cmd;
                ph          = PH_CMD;
            end
            else if (ph == PH_WRITE || (ph == PH_CMD && !rd_q.is_read))
            begin
                if (ph == PH_CMD)
                begin
                    ph  = PH_WRITE;
                    cnt = 3'd0;
                end
                ev_tx_valid = 1'b1;
                ev_tx_byte  = get_byte(rd_q.payload, cnt);
                cnt         = cnt + 3'd1;
                if (cnt >= rd_q.length)
                begin
                    ph = PH_STOP;
                end
            end
        end
        if (in_rxne_reg && ph == PH_READ)
        begin
            if (cnt >= rd_q.length)
            begin
                ph = PH_STOP;
            end
            else
            begin
                if (cnt < 3'(PAY_BYTES))
                begin
                    ev_pay[{cnt[BYTE_SEL_W-1:0], 3'b000} +: 8] = in_rx_reg;
                end
                ev_wr = 1'b1;
                cnt   = cnt + 3'd1;
            end
        end
        if (in_stopf_reg && ph == PH_STOP)
        begin
            ev_stop = 1'b1;
            ph      = PH_START;
        end
        if (in_tc_reg && ph == PH_CMD)
        begin
            ev_xk = XFER_RESTART;
            ev_xc = rd_q.length + 3'd1;
            ph    = PH_READ;
            cnt   = 3'd0;
        end
        ev_phase = ph;
        ev_cnt   = cnt;
    end

    always_comb
    begin
        if (rd_q.is_read)
        begin
            lau_xk = XFER_READ_CMD;
            lau_xc = 3'd1;
        end
        else
        begin
            lau_xk = XFER_WRITE;
            lau_xc = rd_q.length + 3'd2;
        end
    end

    assign mem_we = cmd.write_entry | (cmd.do_event & ev_wr);

    always_comb
    begin
        if (cmd.write_entry)
        begin
            mem_waddr         = in_index_reg;
            mem_wdata.cmd     = in_cmd_reg;
            mem_wdata.length  = clamp_length(in_length_reg);
            mem_wdata.is_read = in_is_read_reg;
            mem_wdata.payload = in_payload_reg;
        end
        else
        begin
            mem_waddr         = cur_reg;
            mem_wdata         = rd_q;
            mem_wdata.payload = ev_pay;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_q <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_index_reg   <= entry_index[IDX_W-1:0];
            in_cmd_reg     <= entry_cmd;
            in_length_reg  <= entry_length;
            in_is_read_reg <= entry_is_read;
            in_payload_reg <= entry_payload;
            in_tick_reg    <= request_tick;
            in_rx_reg      <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_kind_reg          <= KIND_WRITE;
            in_txis_reg          <= 1'b0;
            in_rxne_reg          <= 1'b0;
            in_stopf_reg         <= 1'b0;
            in_tc_reg            <= 1'b0;
            phase_reg            <= PH_START;
            cnt_reg              <= 3'd0;
            cur_reg              <= '0;
            active_reg           <= 1'b0;
            tick_pending_reg     <= 1'b0;
            res_tx_valid_reg     <= 1'b0;
            res_tx_byte_reg      <= 8'd0;
            res_xk_reg           <= XFER_NONE;
            res_xc_reg           <= 3'd0;
            res_accepted_reg     <= 1'b0;
            res_entry_done_reg   <= 1'b0;
            res_done_index_reg   <= '0;
            res_done_payload_reg <= '0;
            res_seq_end_reg      <= 1'b0;
            res_tick_reg         <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                in_kind_reg  <= kind;
                in_txis_reg  <= flag_txis;
                in_rxne_reg  <= flag_rxne;
                in_stopf_reg <= flag_stopf;
                in_tc_reg    <= flag_tc;
            end
            if (cmd.clear)
            begin
                res_tx_valid_reg     <= 1'b0;
                res_tx_byte_reg      <= 8'd0;
                res_xk_reg           <= XFER_NONE;
                res_xc_reg           <= 3'd0;
                res_accepted_reg     <= 1'b0;
                res_entry_done_reg   <= 1'b0;
                res_done_index_reg   <= '0;
                res_done_payload_reg <= '0;
                res_seq_end_reg      <= 1'b0;
                res_tick_reg         <= 1'b0;
            end
            if (cmd.start_seq)
            begin
                cur_reg          <= in_index_reg;
                tick_pending_reg <= in_tick_reg;
                active_reg       <= 1'b1;
                res_accepted_reg <= 1'b1;
            end
            if (cmd.do_launch)
            begin
                phase_reg  <= PH_START;
                res_xk_reg <= lau_xk;
                res_xc_reg <= lau_xc;
            end
            if (cmd.do_event)
            begin
                phase_reg        <= ev_phase;
                cnt_reg          <= ev_cnt;
                res_tx_valid_reg <= ev_tx_valid;
                res_tx_byte_reg  <= ev_tx_byte;
                res_xk_reg       <= ev_xk;
                res_xc_reg       <= ev_xc;
                if (ev_stop)
                begin
                    res_entry_done_reg   <= 1'b1;
                    res_done_index_reg   <= cur_reg;
                    res_done_payload_reg <= rd_q.payload;
                    cur_reg              <= next_idx;
                end
            end
            if (cmd.do_next)
            begin
                phase_reg <= PH_START;
                if (rd_q.cmd == 8'd0)
                begin
                    active_reg       <= 1'b0;
                    res_seq_end_reg  <= 1'b1;
                    res_tick_reg     <= tick_pending_reg;
                    tick_pending_reg <= 1'b0;
                end
                else
                begin
                    res_xk_reg <= lau_xk;
                    res_xc_reg <= lau_xc;
                end
            end
        end
    end

    assign status.kind     = in_kind_reg;
    assign status.active   = active_reg;
    assign status.stop_hit = ev_stop;

    assign tx_valid     = res_tx_valid_reg;
    assign tx_byte      = res_tx_byte_reg;
    assign xfer_kind    = res_xk_reg;
    assign xfer_count   = res_xc_reg;
    assign accepted     = res_accepted_reg;
    assign busy_res     = active_reg;
    assign entry_done   = res_entry_done_reg;
    assign done_index   = 4'(res_done_index_reg);
    assign done_payload = res_done_payload_reg;
    assign sequence_end = res_seq_end_reg;
    assign tick_request = res_tick_reg;

endmodule

// ----- sv/sct_controller.sv -----
// Control state machine of the sequencer that steps the datapath through one transaction.
module sct_controller (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    output logic             done,
    input  sct_pkg::status_t status,
    output sct_pkg::cmd_t    cmd
);
    import sct_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DISPATCH = 6'b000010,
        S_LAUNCH   = 6'b000100,
        S_EVENT    = 6'b001000,
        S_NEXT     = 6'b010000,
        S_RESULT   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_CUR;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    cmd.clear   = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                priority if (status.kind == KIND_WRITE)
                begin
                    cmd.write_entry = 1'b1;
                    state_next      = S_RESULT;
                end
                else if (status.kind == KIND_START && !status.active)
                begin
                    cmd.start_seq = 1'b1;
                    cmd.rd_sel    = RD_ITEM;
                    state_next    = S_LAUNCH;
                end
                else if (status.kind == KIND_EVENT && status.active)
                begin
                    cmd.rd_sel = RD_CUR;
                    state_next = S_EVENT;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_LAUNCH:
            begin
                cmd.do_launch = 1'b1;
                state_next    = S_RESULT;
            end
            S_EVENT:
            begin
                cmd.do_event = 1'b1;
                cmd.rd_sel   = RD_NEXT;
                state_next   = status.stop_hit ? S_NEXT : S_RESULT;
            end
            S_NEXT:
            begin
                cmd.do_next = 1'b1;
                state_next  = S_RESULT;
            end
            S_RESULT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_RESULT);

endmodule

// ----- sv/smbus_command_table_sequencer.sv -----
// Top level of the SMBus command table sequencer: controller and datapath.
//
// A transaction is taken when start is high and busy is low; its result is shown for exactly one
// cycle with done high, and the receiver cannot hold it off. A table write or an ignored item
// goes from dispatch straight to the result state, a sequence start passes a launch state and an
// event item an event state, and an event item whose stop completes an entry also a next state,
// since the command table is a memory with one registered read port that is read once per table
// entry looked at. Busy falls in the cycle after done; no new transaction is taken before then.
module smbus_command_table_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic [1:0]  kind,
    input  logic [3:0]  entry_index,
    input  logic [7:0]  entry_cmd,
    input  logic [2:0]  entry_length,
    input  logic        entry_is_read,
    input  logic [31:0] entry_payload,
    input  logic        request_tick,
    input  logic        flag_txis,
    input  logic        flag_rxne,
    input  logic        flag_stopf,
    input  logic        flag_tc,
    input  logic [7:0]  rx_byte,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic [1:0]  xfer_kind,
    output logic [2:0]  xfer_count,
    output logic        accepted,
    output logic        busy_res,
    output logic        entry_done,
    output logic [3:0]  done_index,
    output logic [31:0] done_payload,
    output logic        sequence_end,
    output logic        tick_request
);
    import sct_pkg::*;

    cmd_t    cmd;
    status_t status;

    sct_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .status (status),
        .cmd    (cmd)
    );

    sct_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .kind          (kind),
        .entry_index   (entry_index),
        .entry_cmd     (entry_cmd),
        .entry_length  (entry_length),
        .entry_is_read (entry_is_read),
        .entry_payload (entry_payload),
        .request_tick  (request_tick),
        .flag_txis     (flag_txis),
        .flag_rxne     (flag_rxne),
        .flag_stopf    (flag_stopf),
        .flag_tc       (flag_tc),
        .rx_byte       (rx_byte),
        .tx_valid      (tx_valid),
        .tx_byte       (tx_byte),
        .xfer_kind     (xfer_kind),
        .xfer_count    (xfer_count),
        .accepted      (accepted),
        .busy_res      (busy_res),
        .entry_done    (entry_done),
        .done_index    (done_index),
        .done_payload  (done_payload),
        .sequence_end  (sequence_end),
        .tick_request  (tick_request)
    );

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a transaction in progress");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done && accepted |-> busy_res && !entry_done && !sequence_end)
        else $error("accepted start did not leave the sequencer running");

    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done && sequence_end |-> !busy_res && entry_done)
        else $error("sequence end without a finished entry or while still running");

    a_tick_needs_end: assert property (@(posedge clk) disable iff (!rst_n)
        done && tick_request |-> sequence_end)
        else $error("tick request raised outside a sequence end");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the SMBus command table sequencer with directed and random traffic.
module tb_top;
    import sct_pkg::*;

    localparam int RANDOM_ITEMS = 1550;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 12;
    localparam int PRINT_CAP    = 50;

    typedef struct {
        logic [1:0]  kind;
        logic [3:0]  index;
        logic [7:0]  cmd;
        logic [2:0]  length;
        logic        is_read;
        logic [31:0] payload;
        logic        tick;
        logic        txis;
        logic        rxne;
        logic        stopf;
        logic        tc;
        logic [7:0]  rx;
    } sct_item_t;

    typedef struct {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic [1:0]  xfer_kind;
        logic [2:0]  xfer_count;
        logic        accepted;
        logic        busy_res;
        logic        entry_done;
        logic [3:0]  done_index;
        logic [31:0] done_payload;
        logic        sequence_end;
        logic        tick_request;
    } bus_action_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        done;
    logic [1:0]  kind = '0;
    logic [3:0]  entry_index = '0;
    logic [7:0]  entry_cmd = '0;
    logic [2:0]  entry_length = '0;
    logic        entry_is_read = 1'b0;
    logic [31:0] entry_payload = '0;
    logic        request_tick = 1'b0;
    logic        flag_txis = 1'b0;
    logic        flag_rxne = 1'b0;
    logic        flag_stopf = 1'b0;
    logic        flag_tc = 1'b0;
    logic [7:0]  rx_byte = '0;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [1:0]  xfer_kind;
    logic [2:0]  xfer_count;
    logic        accepted;
    logic        busy_res;
    logic        entry_done;
    logic [3:0]  done_index;
    logic [31:0] done_payload;
    logic        sequence_end;
    logic        tick_request;

    bus_action_t due_actions[$];
    int          error_count = 0;
    int          idle_cycles = 0;

    logic [7:0]  tbl_cmd [TABLE_DEPTH];
    logic [2:0]  tbl_len [TABLE_DEPTH];
    logic        tbl_rd  [TABLE_DEPTH];
    logic [31:0] tbl_pay [TABLE_DEPTH];
    phase_t      seq_phase = PH_START;
    logic [2:0]  byte_cnt = '0;
    logic [3:0]  cur_idx = '0;
    logic        seq_active = 1'b0;
    logic        tick_pend = 1'b0;

    smbus_command_table_sequencer u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .done(done),
        .kind(kind),
        .entry_index(entry_index),
        .entry_cmd(entry_cmd),
        .entry_length(entry_length),
        .entry_is_read(entry_is_read),
        .entry_payload(entry_payload),
        .request_tick(request_tick),
        .flag_txis(flag_txis),
        .flag_rxne(flag_rxne),
        .flag_stopf(flag_stopf),
        .flag_tc(flag_tc),
        .rx_byte(rx_byte),
        .tx_valid(tx_valid),
        .tx_byte(tx_byte),
        .xfer_kind(xfer_kind),
        .xfer_count(xfer_count),
        .accepted(accepted),
        .busy_res(busy_res),
        .entry_done(entry_done),
        .done_index(done_index),
        .done_payload(done_payload),
        .sequence_end(sequence_end),
        .tick_request(tick_request)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void launch_entry(inout bus_action_t act);
        seq_phase = PH_START;
        if (!tbl_rd[cur_idx])
        begin
            act.xfer_kind  = XFER_WRITE;
            act.xfer_count = tbl_len[cur_idx] + 3'd2;
        end
        else
        begin
            act.xfer_kind  = XFER_READ_CMD;
            act.xfer_count = 3'd1;
        end
    endfunction

    function automatic bus_action_t step_sequencer(input sct_item_t it);
        bus_action_t act;
        logic [3:0]  here;
        logic [2:0]  len;
        logic [2:0]  wr_len;
        act = '{default: '0};
        case (it.kind)
            KIND_WRITE:
            begin
                wr_len = (it.length == 3'd0) ? 3'd1 : it.length;
                if (wr_len > 3'(MAX_PAYLOAD_BYTES))
                begin
                    wr_len = 3'(MAX_PAYLOAD_BYTES);
                end
                tbl_cmd[it.index] = it.cmd;
                tbl_len[it.index] = wr_len;
                tbl_rd[it.index]  = it.is_read;
                tbl_pay[it.index] = it.payload;
            end
            KIND_START:
            begin
                if (!seq_active)
                begin
                    cur_idx      = it.index;
                    tick_pend    = it.tick;
                    seq_active   = 1'b1;
                    act.accepted = 1'b1;
                    launch_entry(act);
                end
            end
            KIND_EVENT:
            begin
                if (seq_active)
                begin
                    here = cur_idx;
                    len  = tbl_len[here];
                    if (it.txis)
                    begin
                        if (seq_phase == PH_START)
                        begin
                            act.tx_valid = 1'b1;
                            act.tx_byte  = tbl_cmd[here];
                            seq_phase    = PH_CMD;
                        end
                        else if (seq_phase == PH_WRITE || (seq_phase == PH_CMD && !tbl_rd[here]))
                        begin
                            if (seq_phase == PH_CMD)
                            begin
                                seq_phase = PH_WRITE;
                                byte_cnt  = 3'd0;
                            end
                            act.tx_valid = 1'b1;
                            act.tx_byte  = 8'(tbl_pay[here] >> (8 * byte_cnt));
                            byte_cnt     = byte_cnt + 3'd1;
                            if (byte_cnt >= len)
                            begin
                                seq_phase = PH_STOP;
                            end
                        end
                    end
                    if (it.rxne && seq_phase == PH_READ)
                    begin
                        if (byte_cnt >= len)
                        begin
                            seq_phase = PH_STOP;
                        end
                        else
                        begin
                            tbl_pay[here][8 * byte_cnt +: 8] = it.rx;
                            byte_cnt = byte_cnt + 3'd1;
                        end
                    end
                    if (it.stopf && seq_phase == PH_STOP)
                    begin
                        act.entry_done   = 1'b1;
                        act.done_index   = here;
                        act.done_payload = tbl_pay[here];
                        cur_idx          = here + 4'd1;
                        if (tbl_cmd[cur_idx] == 8'h00)
                        begin
                            seq_active       = 1'b0;
                            seq_phase        = PH_START;
                            act.sequence_end = 1'b1;
                            act.tick_request = tick_pend;
                            tick_pend        = 1'b0;
                        end
                        else
                        begin
                            launch_entry(act);
                        end
                    end
                    if (it.tc && seq_phase == PH_CMD)
                    begin
                        act.xfer_kind  = XFER_RESTART;
                        act.xfer_count = len + 3'd1;
                        seq_phase      = PH_READ;
                        byte_cnt       = 3'd0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        act.busy_res = seq_active;
        return act;
    endfunction

    function automatic sct_item_t noise_item();
        sct_item_t it;
        it.kind    = 2'($urandom);
        it.index   = 4'($urandom);
        it.cmd     = 8'($urandom);
        it.length  = 3'($urandom);
        it.is_read = 1'($urandom);
        it.payload = $urandom;
        it.tick    = 1'($urandom);
        it.txis    = 1'($urandom);
        it.rxne    = 1'($urandom);
        it.stopf   = 1'($urandom);
        it.tc      = 1'($urandom);
        it.rx      = 8'($urandom);
        return it;
    endfunction

    function automatic sct_item_t make_write(input logic [3:0] idx, input logic [7:0] cmd,
                                             input logic [2:0] len, input logic rd,
                                             input logic [31:0] pay);
        sct_item_t it;
        it         = noise_item();
        it.kind    = KIND_WRITE;
        it.index   = idx;
        it.cmd     = cmd;
        it.length  = len;
        it.is_read = rd;
        it.payload = pay;
        return it;
    endfunction

    function automatic sct_item_t make_start(input logic [3:0] idx, input logic tick);
        sct_item_t it;
        it       = noise_item();
        it.kind  = KIND_START;
        it.index = idx;
        it.tick  = tick;
        return it;
    endfunction

    function automatic sct_item_t make_event(input logic [3:0] flags, input logic [7:0] rx);
        sct_item_t it;
        it = noise_item();
        it.kind = KIND_EVENT;
        {it.txis, it.rxne, it.stopf, it.tc} = flags;
        it.rx = rx;
        return it;
    endfunction

    function automatic sct_item_t random_write();
        sct_item_t it;
        it      = noise_item();
        it.kind = KIND_WRITE;
        if ($urandom_range(0, 4) == 0)
        begin
            it.cmd = 8'h00;
        end
        else
        begin
            it.cmd = 8'($urandom_range(1, 255));
        end
        return it;
    endfunction

    // Mostly the flag that the current phase waits for, sometimes a random mix.
    function automatic sct_item_t next_event();
        sct_item_t it;
        logic [3:0] flags;
        flags = 4'b0000;
        if ($urandom_range(0, 9) < 2)
        begin
            flags = 4'($urandom);
        end
        else
        begin
            case (seq_phase)
                PH_START:
                begin
                    flags = 4'b1000;
                end
                PH_CMD:
                begin
                    flags = tbl_rd[cur_idx] ? 4'b0001 : 4'b1000;
                end
                PH_WRITE:
                begin
                    flags = 4'b1000;
                    if (int'(byte_cnt) + 1 >= int'(tbl_len[cur_idx]) && $urandom_range(0, 1) == 1)
                    begin
                        flags = 4'b1010;
                    end
                end
                PH_READ:
                begin
                    flags = 4'b0100;
                    if (byte_cnt >= tbl_len[cur_idx] && $urandom_range(0, 2) == 0)
                    begin
                        flags = 4'b0110;
                    end
                end
                default:
                begin
                    flags = 4'b0010;
                end
            endcase
        end
        it = make_event(flags, 8'($urandom));
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < PRINT_CAP)
        begin
            $display("ERROR at %0t: %s got %0h expected %0h", $time, what, got, want);
        end
        error_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            report_mismatch(what, got, want);
        end
    endtask

    task automatic send_item(input sct_item_t it);
        start         <= 1'b1;
        kind          <= it.kind;
        entry_index   <= it.index;
        entry_cmd     <= it.cmd;
        entry_length  <= it.length;
        entry_is_read <= it.is_read;
        entry_payload <= it.payload;
        request_tick  <= it.tick;
        flag_txis     <= it.txis;
        flag_rxne     <= it.rxne;
        flag_stopf    <= it.stopf;
        flag_tc       <= it.tc;
        rx_byte       <= it.rx;
        do
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0);
        due_actions.push_back(step_sequencer(it));
    endtask

    task automatic random_gap(input int seq_no);
        int roll;
        roll = $urandom_range(0, 99);
        if ((seq_no % 250) < 40)
        begin
            roll = 0;
        end
        if (roll >= 60)
        begin
            start <= 1'b0;
            if (roll < 95)
            begin
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                repeat ($urandom_range(10, 40)) @(posedge clk);
            end
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (due_actions.size() != 0)
        begin
            @(posedge clk);
        end
        @(posedge clk);
    endtask

    task automatic test_table_load();
        send_item(make_write(4'd15, 8'hFF, 3'd7, 1'b0, 32'hFFFF_FFFF));
        send_item(make_write(4'd0, 8'h1D << 1, 3'd0, 1'b1, 32'h0000_0000));
        send_item(make_write(4'd1, 8'h00, 3'd1, 1'b0, 32'h1234_5678));
        send_item(make_write(4'd2, 8'h00, 3'd5, 1'b1, 32'h0000_0000));
        wait_drained();
    endtask

    task automatic test_write_entry_wrap();
        send_item(make_start(4'd15, 1'b1));
        send_item(make_start(4'd0, 1'b0));
        send_item(make_event(4'b1110, 8'hFF));
        send_item(make_event(4'b1001, 8'h00));
        send_item(make_event(4'b1000, 8'h00));
        send_item(make_event(4'b1000, 8'h00));
        send_item(make_event(4'b0000, 8'h00));
        send_item(make_write(4'd14, 8'h01, 3'd3, 1'b1, 32'h8000_0001));
        send_item(make_event(4'b1010, 8'h00));
        wait_drained();
    endtask

    task automatic test_read_entry();
        sct_item_t it;
        it      = noise_item();
        it.kind = 2'd3;
        send_item(it);
        send_item(make_event(4'b1000, 8'h00));
        send_item(make_event(4'b1000, 8'h00));
        send_item(make_event(4'b0001, 8'h00));
        send_item(make_event(4'b0100, 8'hFF));
        send_item(make_event(4'b0100, 8'h5A));
        send_item(make_event(4'b0110, 8'h00));
        wait_drained();
    endtask

    task automatic test_idle_and_terminator();
        send_item(make_event(4'b1111, 8'hFF));
        send_item(make_start(4'd1, 1'b0));
        send_item(make_event(4'b1000, 8'h00));
        send_item(make_event(4'b1010, 8'h00));
        wait_drained();
    endtask

    task automatic test_random_traffic();
        sct_item_t it;
        int        counted;
        int        sent;
        int        sel;
        logic      counts;
        counted = 0;
        sent    = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            it       = random_write();
            it.index = 4'(i);
            send_item(it);
            random_gap(sent);
            sent++;
            counted++;
        end
        while (counted < RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 99);
            if (seq_active)
            begin
                if (sel < 88)
                begin
                    it = next_event();
                end
                else if (sel < 94)
                begin
                    it = random_write();
                end
                else if (sel < 97)
                begin
                    it = make_start(4'($urandom), 1'($urandom));
                end
                else
                begin
                    it      = noise_item();
                    it.kind = 2'd3;
                end
            end
            else
            begin
                if (sel < 60)
                begin
                    it = make_start(4'($urandom), 1'($urandom));
                end
                else if (sel < 85)
                begin
                    it = random_write();
                end
                else if (sel < 95)
                begin
                    it = make_event(4'($urandom), 8'($urandom));
                end
                else
                begin
                    it      = noise_item();
                    it.kind = 2'd3;
                end
            end
            counts = !(it.kind == 2'd3 || (it.kind == KIND_EVENT && !seq_active)
                       || (it.kind == KIND_START && seq_active));
            send_item(it);
            if (counts)
            begin
                counted++;
            end
            sent++;
            if ($urandom_range(0, 99) == 0)
            begin
                wait_drained();
            end
            else
            begin
                random_gap(sent);
            end
        end
        wait_drained();
    endtask

    always @(posedge clk)
    begin : check_actions
        bus_action_t want;
        if (rst_n && done === 1'b1)
        begin
            if (due_actions.size() == 0)
            begin
                report_mismatch("result with no transaction pending", 32'd1, 32'd0);
            end
            else
            begin
                want = due_actions.pop_front();
                check_field("tx_valid", 32'(tx_valid), 32'(want.tx_valid));
                check_field("tx_byte", 32'(tx_byte), 32'(want.tx_byte));
                check_field("xfer_kind", 32'(xfer_kind), 32'(want.xfer_kind));
                check_field("xfer_count", 32'(xfer_count), 32'(want.xfer_count));
                check_field("accepted", 32'(accepted), 32'(want.accepted));
                check_field("busy_res", 32'(busy_res), 32'(want.busy_res));
                check_field("entry_done", 32'(entry_done), 32'(want.entry_done));
                check_field("done_index", 32'(done_index), 32'(want.done_index));
                check_field("done_payload", done_payload, want.done_payload);
                check_field("sequence_end", 32'(sequence_end), 32'(want.sequence_end));
                check_field("tick_request", 32'(tick_request), 32'(want.tick_request));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && busy === 1'b0) || done === 1'b1)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_table_load();
        test_write_entry_wrap();
        test_read_entry();
        test_idle_and_terminator();
        test_random_traffic();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && due_actions.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/sct_pkg.sv
sv/sct_datapath.sv
sv/sct_controller.sv
sv/smbus_command_table_sequencer.sv
tb/tb_top.sv
